[hdl/clq_pkg.sv]
package clq_pkg;

	localparam int RING_DEPTH_DEF = 64;

	localparam logic [1:0] OP_PUSH    = 2'd0;
	localparam logic [1:0] OP_ARM     = 2'd1;
	localparam logic [1:0] OP_SERVICE = 2'd2;
	localparam logic [1:0] OP_NONE    = 2'd3;

	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_TILDE     = 8'h7E;
	localparam logic [7:0] CH_BACKSPACE = 8'h08;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;

	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	typedef enum logic [1:0] {
		CMD_PUSH,
		CMD_ARM,
		CMD_SERVICE,
		CMD_NOP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  key_char;
		logic [15:0] request_count;
	} cmd_t;

	typedef struct packed {
		logic        accepted;
		logic        empty_res;
		logic        echo_valid;
		logic [7:0]  echo_char;
		logic        store_valid;
		logic [15:0] store_index;
		logic [7:0]  store_char;
		logic        done_res;
		logic [15:0] done_count;
	} res_t;

	typedef enum logic {
		BK_IDLE,
		BK_READ
	} back_state_t;

endpackage

[hdl/cooked_line_input_queue.sv]
// Canonical-mode keyboard line input. Each input beat carries an op: push a key
// into the RING_DEPTH-byte ring (dropped when full), arm a read request, or
// service one buffered character; every beat yields exactly one result beat.
// A two-entry command queue decouples the input side from the execution side,
// and a two-entry result queue holds finished results, so either side may
// stall. Pushes, arms and services of an empty ring finish in the execution
// unit straight from its idle state; a service that reads the ring passes
// through a read state, because the ring is a memory with a registered read
// port. The ring contents are not cleared by reset; only written bytes are
// ever read.
module cooked_line_input_queue import clq_pkg::*; #(
	parameter int RING_DEPTH = RING_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  op,
	input  logic [7:0]  key_char,
	input  logic [15:0] request_count,
	output logic        empty,
	input  logic        pop,
	output logic        accepted,
	output logic        empty_res,
	output logic        echo_valid,
	output logic [7:0]  echo_char,
	output logic        store_valid,
	output logic [15:0] store_index,
	output logic [7:0]  store_char,
	output logic        done_res,
	output logic [15:0] done_count
);

	cmd_t cmd;
	logic cmd_empty;
	logic cmd_pop;
	logic res_full;
	logic res_push;
	res_t res;
	res_t res_out;

	clq_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.op            (op),
		.key_char      (key_char),
		.request_count (request_count),
		.cmd_pop       (cmd_pop),
		.cmd_empty     (cmd_empty),
		.cmd           (cmd)
	);

	clq_back #(
		.RING_DEPTH (RING_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res)
	);

	clq_out_queue u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res_in   (res),
		.res_full (res_full),
		.pop      (pop),
		.empty    (empty),
		.res_out  (res_out)
	);

	assign accepted    = res_out.accepted;
	assign empty_res   = res_out.empty_res;
	assign echo_valid  = res_out.echo_valid;
	assign echo_char   = res_out.echo_char;
	assign store_valid = res_out.store_valid;
	assign store_index = res_out.store_index;
	assign store_char  = res_out.store_char;
	assign done_res    = res_out.done_res;
	assign done_count  = res_out.done_count;

endmodule

[hdl/clq_front.sv]
module clq_front import clq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  op,
	input  logic [7:0]  key_char,
	input  logic [15:0] request_count,
	input  logic        cmd_pop,
	output logic        cmd_empty,
	output cmd_t        cmd
);

	cmd_t       slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       accept;
	cmd_t       cls;

	// Decode the opcode once here so the back end only sees a command kind.
	always_comb begin
		cls.key_char      = key_char;
		cls.request_count = request_count;
		unique case (op)
			OP_PUSH:    cls.kind = CMD_PUSH;
			OP_ARM:     cls.kind = CMD_ARM;
			OP_SERVICE: cls.kind = CMD_SERVICE;
			OP_NONE:    cls.kind = CMD_NOP;
		endcase
	end

	assign full      = (cnt_q == 2'd2);
	assign cmd_empty = (cnt_q == 2'd0);
	assign accept    = push && !full;
	assign cmd       = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (accept) begin
			slot_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (accept) begin
				wr_q <= !wr_q;
			end
			if (cmd_pop) begin
				rd_q <= !rd_q;
			end
			if (accept && !cmd_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!accept && cmd_pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

[hdl/clq_back.sv]
module clq_back import clq_pkg::*; #(
	parameter int RING_DEPTH = RING_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_empty,
	input  cmd_t cmd,
	output logic cmd_pop,
	input  logic res_full,
	output logic res_push,
	output res_t res
);

	localparam int PTR_W  = $clog2(RING_DEPTH);
	localparam int FILL_W = $clog2(RING_DEPTH + 1);

	logic [7:0]        ring [RING_DEPTH];
	logic [7:0]        rdata_q;
	back_state_t       state_q;
	back_state_t       state_d;
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic [15:0]       rem_q;
	logic [15:0]       del_q;
	logic [15:0]       rem_d;
	logic [15:0]       del_d;
	logic              take;
	logic              ring_empty;
	logic              ring_full;
	logic              mem_we;
	logic              mem_re;
	logic              arm_load;
	logic              char_done;
	logic              printable;

	assign take       = !cmd_empty && !res_full;
	assign ring_empty = (fill_q == '0);
	assign ring_full  = (fill_q == FILL_W'(RING_DEPTH));
	assign printable  = (rdata_q >= CH_SPACE) && (rdata_q <= CH_TILDE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (take && cmd.kind == CMD_SERVICE && !ring_empty) begin
					state_d = BK_READ;
				end
			end
			BK_READ: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop   = 1'b0;
		res_push  = 1'b0;
		res       = '0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		arm_load  = 1'b0;
		char_done = 1'b0;
		rem_d     = rem_q;
		del_d     = del_q;
		unique case (state_q)
			BK_IDLE: begin
				if (take) begin
					cmd_pop = 1'b1;
					unique case (cmd.kind)
						CMD_PUSH: begin
							res_push = 1'b1;
							if (!ring_full) begin
								mem_we       = 1'b1;
								res.accepted = 1'b1;
							end
						end
						CMD_ARM: begin
							res_push = 1'b1;
							arm_load = 1'b1;
						end
						CMD_SERVICE: begin
							if (ring_empty) begin
								res_push      = 1'b1;
								res.empty_res = 1'b1;
							end else begin
								mem_re = 1'b1;
							end
						end
						CMD_NOP: res_push = 1'b1;
					endcase
				end
			end
			BK_READ: begin
				// Room in the result queue was checked when the command was taken.
				res_push  = 1'b1;
				char_done = 1'b1;
				if (rem_q != '0) begin
					if (printable) begin
						res.echo_valid  = 1'b1;
						res.echo_char   = rdata_q;
						res.store_valid = 1'b1;
						res.store_index = del_q;
						res.store_char  = rdata_q;
						if (del_q != COUNT_MAX) begin
							del_d = del_q + 16'd1;
						end
						rem_d = rem_q - 16'd1;
					end else if (rdata_q == CH_BACKSPACE && del_q != '0) begin
						res.echo_valid = 1'b1;
						res.echo_char  = rdata_q;
						del_d          = del_q - 16'd1;
						if (rem_q != COUNT_MAX) begin
							rem_d = rem_q + 16'd1;
						end
					end
					if (rdata_q == CH_NEWLINE || rem_d == '0) begin
						res.echo_valid = 1'b1;
						res.echo_char  = rdata_q;
						res.done_res   = 1'b1;
						res.done_count = del_d;
						rem_d          = '0;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring[wr_ptr_q] <= cmd.key_char;
		end
		if (mem_re) begin
			rdata_q <= ring[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BK_IDLE;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
			rem_q    <= '0;
			del_q    <= '0;
		end else begin
			state_q <= state_d;
			if (mem_we) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(RING_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
				fill_q   <= fill_q + FILL_W'(1);
			end
			if (mem_re) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(RING_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
				fill_q   <= fill_q - FILL_W'(1);
			end
			if (arm_load) begin
				rem_q <= cmd.request_count;
				del_q <= '0;
			end
			if (char_done) begin
				rem_q <= rem_d;
				del_q <= del_d;
			end
		end
	end

endmodule

[hdl/clq_out_queue.sv]
module clq_out_queue import clq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic res_push,
	input  res_t res_in,
	output logic res_full,
	input  logic pop,
	output logic empty,
	output res_t res_out
);

	res_t       slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       take_beat;

	assign res_full  = (cnt_q == 2'd2);
	assign empty     = (cnt_q == 2'd0);
	assign take_beat = pop && !empty;
	assign res_out   = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (res_push) begin
			slot_q[wr_q] <= res_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (res_push) begin
				wr_q <= !wr_q;
			end
			if (take_beat) begin
				rd_q <= !rd_q;
			end
			if (res_push && !take_beat) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!res_push && take_beat) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule
